@@ rtl/core/http_host_header_validator_defines.svh @@
// Assertion macros for the host header validator.
// Used by http_host_header_validator.sv in rtl/core; no other dependencies.
`ifndef HTTP_HOST_HEADER_VALIDATOR_DEFINES_SVH
`define HTTP_HOST_HEADER_VALIDATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Property holds in every cycle out of reset.
`define HHV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define HHV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define HHV_ASSERT(lbl, clk, rst_n, prop, msg)
`define HHV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/core/hhv_pkg.sv @@
// Shared types and constants of the host header validator.
// No dependencies; used by hhv_byte_step and http_host_header_validator.
`default_nettype none

package hhv_pkg;

	// parse mode, one-hot
	typedef enum logic [2:0] {
		MODE_USUAL   = 3'b001,
		MODE_LITERAL = 3'b010,
		MODE_REST    = 3'b100
	} mode_t;

	typedef struct packed {
		mode_t mode;
		logic  dot_seen;
		logic  was_cut;
		logic  rejected;
		logic  upper;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{
		mode:     MODE_USUAL,
		dot_seen: 1'b0,
		was_cut:  1'b0,
		rejected: 1'b0,
		upper:    1'b0
	};

	localparam int LEN_W = 11;

	typedef struct packed {
		logic             upper;
		logic [LEN_W-1:0] length;
		logic             status;
	} result_t;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;

endpackage

`default_nettype wire

@@ rtl/core/hhv_byte_step.sv @@
// Per-byte state update and end-of-value result for the host validator.
// Purely combinational; uses hhv_pkg.
`default_nettype none

module hhv_byte_step #(
	parameter int MAX_HOST_BYTES = 1024,
	parameter int POS_W          = 11
) (
	input  wire logic [7:0]       host_byte,
	input  wire logic [POS_W-1:0] pos,
	input  wire logic [POS_W-1:0] last_dot,
	input  wire logic [POS_W-1:0] cut_len,
	input  wire hhv_pkg::flags_t  flags,
	output logic [POS_W-1:0]      pos_nxt,
	output logic [POS_W-1:0]      last_dot_nxt,
	output logic [POS_W-1:0]      cut_len_nxt,
	output hhv_pkg::flags_t       flags_nxt,
	output hhv_pkg::result_t      result
);

	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_HOST_BYTES);
	localparam logic [POS_W-1:0] ONE     = POS_W'(1);

	logic [POS_W-1:0] pos_inc;
	logic [POS_W-1:0] hlen;
	logic [POS_W-1:0] hlen_trim;
	logic             bad;

	assign pos_inc = pos + ONE;

	always_comb begin
		pos_nxt      = pos;
		last_dot_nxt = last_dot;
		cut_len_nxt  = cut_len;
		flags_nxt    = flags;
		priority if (flags.rejected) begin
			// value already rejected: ignore the rest
		end else if (pos >= MAX_POS) begin
			flags_nxt.rejected = 1'b1;
		end else begin
			pos_nxt = pos_inc;
			// ordinary bytes match none of these and only advance the position
			if (host_byte == hhv_pkg::CH_DOT) begin
				if (flags.dot_seen && (last_dot + ONE == pos)) begin
					flags_nxt.rejected = 1'b1;
				end else begin
					last_dot_nxt       = pos;
					flags_nxt.dot_seen = 1'b1;
				end
			end else if (host_byte == hhv_pkg::CH_COLON) begin
				if (flags.mode == hhv_pkg::MODE_USUAL) begin
					cut_len_nxt       = pos;
					flags_nxt.was_cut = 1'b1;
					flags_nxt.mode    = hhv_pkg::MODE_REST;
				end
			end else if (host_byte == hhv_pkg::CH_LBRACK) begin
				if (pos == '0) begin
					flags_nxt.mode = hhv_pkg::MODE_LITERAL;
				end
			end else if (host_byte == hhv_pkg::CH_RBRACK) begin
				if (flags.mode == hhv_pkg::MODE_LITERAL) begin
					cut_len_nxt       = pos_inc;
					flags_nxt.was_cut = 1'b1;
					flags_nxt.mode    = hhv_pkg::MODE_REST;
				end
			end else if (host_byte == hhv_pkg::CH_NUL || host_byte == hhv_pkg::CH_SLASH) begin
				flags_nxt.rejected = 1'b1;
			end else if (host_byte >= hhv_pkg::CH_UP_A && host_byte <= hhv_pkg::CH_UP_Z) begin
				flags_nxt.upper = 1'b1;
			end
		end
	end

	// result as seen once this byte is the last one
	always_comb begin
		hlen      = flags_nxt.was_cut ? cut_len_nxt : pos_nxt;
		hlen_trim = hlen;
		if (!flags_nxt.rejected && flags_nxt.dot_seen && hlen != '0
				&& (last_dot_nxt + ONE == hlen)) begin
			hlen_trim = hlen - ONE;
		end
		bad = flags_nxt.rejected || (hlen_trim == '0);
		if (bad) begin
			result = '{upper: 1'b0, length: '0, status: 1'b1};
		end else begin
			result = '{upper: flags_nxt.upper,
				length: hhv_pkg::LEN_W'(hlen_trim), status: 1'b0};
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/http_host_header_validator.sv @@
// Top level of the streaming HTTP Host header validator.
// Depends on hhv_pkg, hhv_byte_step and http_host_header_validator_defines.svh.
//
// Usage:
//  - Slave channel s_*: one header byte per transaction in s_tdata[7:0];
//    s_tlast marks the final byte of the value.
//  - Master channel m_*: one result transaction per value, issued for the
//    byte that carried s_tlast. Bytes without s_tlast produce nothing.
//  - Path: a last byte accepted into the input register goes through the state
//    update into the result register, which drives m_tvalid.
//  - Throughput: one byte per cycle while no last byte is stalled, set by the
//    combinational update in hhv_byte_step from input to state registers.
//  - Receiver stall: the result register holds the pending result; bytes
//    without tlast keep flowing. A second finished value waits in the input
//    register, and s_tready drops only when that last byte finds the result
//    register still occupied.
//  - Reset (arst_n low, asynchronous): both registers empty, parse state
//    back to its idle values; s_tready is high right after reset.
//  - Values longer than MAX_HOST_BYTES bytes are rejected.
`default_nettype none
`include "http_host_header_validator_defines.svh"

module http_host_header_validator #(
	parameter int MAX_HOST_BYTES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] host_byte
	input  wire logic        s_tlast,   // last_byte
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // [0] status, [11:1] host_length,
	                                    // [12] has_uppercase, [15:13] zero
);

	// position counter saturates at MAX_HOST_BYTES, so it must hold that value
	localparam int POS_W = $clog2(MAX_HOST_BYTES + 1);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parse state
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] last_dot_q;
	logic [POS_W-1:0] cut_len_q;
	hhv_pkg::flags_t  flags_q;

	// result register
	logic             out_valid_q;
	hhv_pkg::result_t out_q;

	logic [POS_W-1:0] pos_nxt;
	logic [POS_W-1:0] last_dot_nxt;
	logic [POS_W-1:0] cut_len_nxt;
	hhv_pkg::flags_t  flags_nxt;
	hhv_pkg::result_t result;

	logic in_xfer;
	logic advance;
	logic emit;

	// a byte leaves the input register unless it carries a result that
	// cannot be stored yet
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign emit     = advance && last_s1;
	assign s_tready = !valid_s1 || advance;
	assign in_xfer  = s_tvalid && s_tready;

	hhv_byte_step #(
		.MAX_HOST_BYTES (MAX_HOST_BYTES),
		.POS_W          (POS_W)
	) u_step (
		.host_byte    (byte_s1),
		.pos          (pos_q),
		.last_dot     (last_dot_q),
		.cut_len      (cut_len_q),
		.flags        (flags_q),
		.pos_nxt      (pos_nxt),
		.last_dot_nxt (last_dot_nxt),
		.cut_len_nxt  (cut_len_nxt),
		.flags_nxt    (flags_nxt),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// state returns to idle after each finished value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			last_dot_q <= '0;
			cut_len_q  <= '0;
			flags_q    <= hhv_pkg::FLAGS_RESET;
		end else if (emit) begin
			pos_q      <= '0;
			last_dot_q <= '0;
			cut_len_q  <= '0;
			flags_q    <= hhv_pkg::FLAGS_RESET;
		end else if (advance) begin
			pos_q      <= pos_nxt;
			last_dot_q <= last_dot_nxt;
			cut_len_q  <= cut_len_nxt;
			flags_q    <= flags_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q};

	// checks
	`HHV_ASSERT(a_reject_zero, clk, arst_n,
		!(out_valid_q && out_q.status) || (out_q.length == '0 && !out_q.upper),
		"rejected result carries nonzero fields")
	`HHV_ASSERT(a_valid_len, clk, arst_n,
		!(out_valid_q && !out_q.status) || (out_q.length != '0),
		"accepted result with empty host")
	`HHV_ASSERT(a_pos_sat, clk, arst_n,
		pos_q <= POS_W'(MAX_HOST_BYTES),
		"byte position beyond limit")
	`HHV_ASSERT_NEXT(a_clear_after, clk, arst_n, emit,
		pos_q == '0 && !flags_q.rejected && flags_q.mode == hhv_pkg::MODE_USUAL,
		"parse state not cleared after result")
	`HHV_ASSERT(a_stall_cause, clk, arst_n,
		s_tready || (valid_s1 && last_s1 && out_valid_q && !m_tready),
		"input stalled without a blocked result")

endmodule

`default_nettype wire
